/* rtl/ncs_pkg.sv */
// Shared types and constants for the nearest codeword search block.
`timescale 1ns / 1ps
`default_nettype none

package ncs_pkg;

   // Payload widths
   localparam int VALUE_W = 16;
   localparam int IDX_W   = 8;
   localparam int DIST_W  = 32;
   localparam int CFG_W   = 9;
   localparam int SQ_W    = 32;
   localparam int SUM_W   = 42;

   // Restoring divider: one quotient bit per step over the whole sum
   localparam int DIV_STEPS = SUM_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam int MAX_WORDS_DEF = 256;
   localparam int MAX_DIM_DEF   = 256;

   localparam int CSR_IDX_W = 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DIM       = 1'b0,
      CSR_NUM_WORDS = 1'b1
   } ncs_csr_type;

   typedef struct packed {
      logic clear_we;    // zero one accumulator during the reset sweep
      logic item_load;   // capture a query beat
      logic cb_write;    // write a codebook element from the request beat
      logic scan_issue;  // read one codeword row entry and its accumulator
      logic div_start;
      logic div_step;
      logic out_load;    // move the result into the output register
   } ncs_cmd_type;

   typedef struct packed {
      logic write_ok;    // request beat is an in-range codebook write
      logic query_ok;    // request beat is a query element below dim
      logic query_last;  // request beat is element dim-1
      logic scan_last;   // current scan word is the last one in use
      logic pipe_busy;   // accumulate pipeline still holds words
   } ncs_stat_type;

endpackage

`default_nettype wire

/* rtl/ncs_req_if.sv */
// Request channel: codebook writes and query elements.
`timescale 1ns / 1ps
`default_nettype none

interface ncs_req_if
   import ncs_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic               mode;
   logic [IDX_W-1:0]   word_index;
   logic [IDX_W-1:0]   element_index;
   logic [VALUE_W-1:0] value;

   modport source (output valid, mode, word_index, element_index, value, input ready);
   modport sink (input valid, mode, word_index, element_index, value, output ready);
endinterface

`default_nettype wire

/* rtl/ncs_rsp_if.sv */
// Response channel: nearest codeword index and mean squared distance.
`timescale 1ns / 1ps
`default_nettype none

interface ncs_rsp_if
   import ncs_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [IDX_W-1:0]  best_index;
   logic [DIST_W-1:0] best_distance;

   modport source (output valid, best_index, best_distance, input ready);
   modport sink (input valid, best_index, best_distance, output ready);
endinterface

`default_nettype wire

/* rtl/ncs_datapath.sv */
// Datapath: config registers, codebook and accumulator memories, MSE pipeline, divider.
`timescale 1ns / 1ps
`default_nettype none

module ncs_datapath
   import ncs_pkg::*;
#(
   parameter int MAX_WORDS = MAX_WORDS_DEF,
   parameter int MAX_DIM   = MAX_DIM_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CFG_W-1:0]              csr_data,
   input  logic                          req_mode,
   input  logic [IDX_W-1:0]              req_word_index,
   input  logic [IDX_W-1:0]              req_element_index,
   input  logic [VALUE_W-1:0]            req_value,
   input  ncs_cmd_type                   cmd,
   input  logic [$clog2(MAX_WORDS)-1:0]  scan_word,
   output ncs_stat_type                  stat,
   output logic [IDX_W-1:0]              rsp_best_index,
   output logic [DIST_W-1:0]             rsp_best_distance
);

   localparam int WORD_W   = $clog2(MAX_WORDS);
   localparam int CB_DEPTH = MAX_WORDS * MAX_DIM;
   localparam int CB_AW    = $clog2(CB_DEPTH);

   // configuration
   logic [CFG_W-1:0] dim_ff, num_words_ff;
   logic [CFG_W-1:0] eff_dim, eff_words;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff       <= CFG_W'(1);
         num_words_ff <= CFG_W'(1);
      end else if (csr_write_en) begin
         unique case (ncs_csr_type'(csr_index))
            CSR_DIM:       dim_ff       <= csr_data;
            CSR_NUM_WORDS: num_words_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // zero acts as one, anything past the array size acts as the array size
   always_comb begin
      if (dim_ff == '0)
         eff_dim = CFG_W'(1);
      else if (32'(dim_ff) > 32'(MAX_DIM))
         eff_dim = CFG_W'(MAX_DIM);
      else
         eff_dim = dim_ff;
      if (num_words_ff == '0)
         eff_words = CFG_W'(1);
      else if (32'(num_words_ff) > 32'(MAX_WORDS))
         eff_words = CFG_W'(MAX_WORDS);
      else
         eff_words = num_words_ff;
   end

   // query beat capture
   logic [IDX_W-1:0]   elem_ff;
   logic [VALUE_W-1:0] value_ff;

   always_ff @(posedge clock) begin
      if (cmd.item_load) begin
         elem_ff  <= req_element_index;
         value_ff <= req_value;
      end
   end

   // codebook: single port, row-major by codeword
   logic [VALUE_W-1:0] cb_mem [CB_DEPTH];
   logic [VALUE_W-1:0] cb_rd_ff;
   logic [CB_AW-1:0]   cb_row, cb_col, cb_addr;

   assign cb_row  = cmd.cb_write ? CB_AW'(req_word_index) : CB_AW'(scan_word);
   assign cb_col  = cmd.cb_write ? CB_AW'(req_element_index) : CB_AW'(elem_ff);
   assign cb_addr = cb_row * CB_AW'(MAX_DIM) + cb_col;

   always_ff @(posedge clock) begin
      if (cmd.cb_write)
         cb_mem[cb_addr] <= req_value;
      cb_rd_ff <= cb_mem[cb_addr];
   end

   // accumulators
   logic [SUM_W-1:0]  sum_mem [MAX_WORDS];
   logic [SUM_W-1:0]  sum_rd_ff;
   logic              sum_we;
   logic [WORD_W-1:0] sum_waddr;
   logic [SUM_W-1:0]  sum_wdata;

   // pipeline registers
   logic              v1_ff, v2_ff;
   logic [WORD_W-1:0] w1_ff, w2_ff;
   logic [SQ_W-1:0]   sq_ff;
   logic [SUM_W-1:0]  base_ff;
   logic [VALUE_W:0]  diff;
   logic [VALUE_W-1:0] mag;
   logic [SUM_W:0]    sum_full;
   logic [SUM_W-1:0]  sum_new;

   always_ff @(posedge clock) begin
      if (sum_we)
         sum_mem[sum_waddr] <= sum_wdata;
      sum_rd_ff <= sum_mem[scan_word];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.scan_issue;
         v2_ff <= v1_ff;
      end
   end

   // stage 1: difference and square
   assign diff = {cb_rd_ff[VALUE_W-1], cb_rd_ff} - {value_ff[VALUE_W-1], value_ff};
   assign mag  = diff[VALUE_W] ? VALUE_W'((VALUE_W+1)'(0) - diff) : diff[VALUE_W-1:0];

   always_ff @(posedge clock) begin
      w1_ff   <= scan_word;
      w2_ff   <= w1_ff;
      sq_ff   <= SQ_W'(mag) * SQ_W'(mag);
      base_ff <= (elem_ff == '0) ? '0 : sum_rd_ff;
   end

   // stage 2: saturating accumulate
   assign sum_full = {1'b0, base_ff} + (SUM_W+1)'(sq_ff);
   assign sum_new  = sum_full[SUM_W] ? '1 : sum_full[SUM_W-1:0];

   always_comb begin
      sum_we    = cmd.clear_we | v2_ff;
      sum_waddr = cmd.clear_we ? scan_word : w2_ff;
      sum_wdata = cmd.clear_we ? '0 : sum_new;
   end

   // running minimum, later word wins ties
   logic [SUM_W-1:0]  best_sum_ff;
   logic [WORD_W-1:0] best_idx_ff;

   always_ff @(posedge clock) begin
      if (v2_ff && (w2_ff == '0 || sum_new <= best_sum_ff)) begin
         best_sum_ff <= sum_new;
         best_idx_ff <= w2_ff;
      end
   end

   // restoring divider by dim
   logic [SUM_W-1:0] quo_ff;
   logic [CFG_W-1:0] rem_ff;
   logic [CFG_W:0]   rem_sh;
   logic             rem_ge;

   assign rem_sh = {rem_ff, quo_ff[SUM_W-1]};
   assign rem_ge = rem_sh >= {1'b0, eff_dim};

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         quo_ff <= best_sum_ff;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[SUM_W-2:0], rem_ge};
         rem_ff <= rem_ge ? CFG_W'(rem_sh - {1'b0, eff_dim}) : rem_sh[CFG_W-1:0];
      end
   end

   // output register
   logic [IDX_W-1:0]  best_index_ff;
   logic [DIST_W-1:0] best_distance_ff;

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         best_index_ff    <= IDX_W'(best_idx_ff);
         best_distance_ff <= (|quo_ff[SUM_W-1:DIST_W]) ? '1 : quo_ff[DIST_W-1:0];
      end
   end

   assign rsp_best_index    = best_index_ff;
   assign rsp_best_distance = best_distance_ff;

   // status
   always_comb begin
      stat.write_ok   = !req_mode && (32'(req_word_index) < 32'(MAX_WORDS))
                        && (32'(req_element_index) < 32'(MAX_DIM));
      stat.query_ok   = req_mode && ({1'b0, req_element_index} < eff_dim);
      stat.query_last = {1'b0, req_element_index} == (eff_dim - CFG_W'(1));
      stat.scan_last  = 32'(scan_word) == (32'(eff_words) - 32'd1);
      stat.pipe_busy  = v1_ff | v2_ff;
   end

endmodule

`default_nettype wire

/* rtl/ncs_ctrl.sv */
// Controller: reset sweep, codeword scan, divide and result handoff sequencing.
`timescale 1ns / 1ps
`default_nettype none

module ncs_ctrl
   import ncs_pkg::*;
#(
   parameter int MAX_WORDS = MAX_WORDS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  ncs_stat_type                  stat,
   output ncs_cmd_type                   cmd,
   output logic [$clog2(MAX_WORDS)-1:0]  scan_word
);

   localparam int WORD_W = $clog2(MAX_WORDS);

   typedef enum logic [5:0] {
      S_CLEAR  = 6'b000001,
      S_IDLE   = 6'b000010,
      S_SCAN   = 6'b000100,
      S_DRAIN  = 6'b001000,
      S_DIVIDE = 6'b010000,
      S_FINISH = 6'b100000
   } state_type;

   state_type             state_ff, state_in;
   logic [WORD_W-1:0]     word_ff, word_in;
   logic [DIV_CNT_W-1:0]  div_cnt_ff, div_cnt_in;
   logic                  last_ff, last_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  req_fire;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign scan_word = word_ff;

   always_comb begin
      state_in   = state_ff;
      word_in    = word_ff;
      div_cnt_in = div_cnt_ff;
      last_in    = last_ff;
      cmd        = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_we = 1'b1;
            if (word_ff == WORD_W'(MAX_WORDS - 1)) begin
               word_in  = '0;
               state_in = S_IDLE;
            end else begin
               word_in = word_ff + WORD_W'(1);
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               cmd.cb_write = stat.write_ok;
               if (stat.query_ok) begin
                  cmd.item_load = 1'b1;
                  last_in       = stat.query_last;
                  word_in       = '0;
                  state_in      = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (stat.scan_last)
               state_in = S_DRAIN;
            else
               word_in = word_ff + WORD_W'(1);
         end
         S_DRAIN: begin
            if (!stat.pipe_busy) begin
               if (last_ff) begin
                  cmd.div_start = 1'b1;
                  div_cnt_in    = '0;
                  state_in      = S_DIVIDE;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1))
               state_in = S_FINISH;
            else
               div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
         end
         S_FINISH: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.out_load)
         rsp_valid_in = 1'b1;
      else if (rsp_ready)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         word_ff      <= '0;
         div_cnt_ff   <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word_ff      <= word_in;
         div_cnt_ff   <= div_cnt_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // a pending result is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over an unaccepted beat");

   // codebook port is either written or scanned, never both
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.cb_write && cmd.scan_issue))
      else $error("codebook port conflict");

   // divider sees the final minimum only
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !stat.pipe_busy)
      else $error("divide started with words in flight");

   // a new beat only enters after the accumulate pipeline has drained
   assert property (@(posedge clock) disable iff (reset)
      req_fire |-> !stat.pipe_busy)
      else $error("request accepted while pipeline busy");

   // loaded result shows on the port next cycle
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("result lost after load");

endmodule

`default_nettype wire

/* rtl/nearest_codeword_search_top.sv */
// Nearest codeword search by mean squared error: top level.
//
// Request beats (req_bus) with mode 0 write one codebook element at
// (word_index, element_index) when the beat is taken. Mode 1 beats carry
// one query element each, sent in order from element 0. Each query element
// walks every codeword in use through a 3-stage read/square/accumulate
// pipeline, one codeword per cycle. Element 0 restarts the sums.
// On element dim-1 the minimum sum (highest index on ties) is divided by dim
// in a bit-serial divider, and the result beat (rsp_bus) carries
// best_index and best_distance. One beat is worked on at a time;
// req_bus.ready is high only when the block is free.
// Results sit in an output register; while the receiver stalls, work goes
// on and only the next finished result waits for the register to drain.
// After reset the accumulators are swept to zero with req_bus.ready low.
// dim and num_words reset to 1. The user must see that they are written
// through the csr_ port only while the block is idle; the block does not
// enforce it.
`timescale 1ns / 1ps
`default_nettype none

module nearest_codeword_search_top
   import ncs_pkg::*;
#(
   parameter int MAX_WORDS = MAX_WORDS_DEF,
   parameter int MAX_DIM   = MAX_DIM_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   ncs_req_if.sink              req_bus,
   ncs_rsp_if.source            rsp_bus,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data
);

   ncs_cmd_type                  cmd;
   ncs_stat_type                 stat;
   logic [$clog2(MAX_WORDS)-1:0] scan_word;

   ncs_ctrl #(
      .MAX_WORDS (MAX_WORDS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat),
      .cmd       (cmd),
      .scan_word (scan_word)
   );

   ncs_datapath #(
      .MAX_WORDS (MAX_WORDS),
      .MAX_DIM   (MAX_DIM)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_mode          (req_bus.mode),
      .req_word_index    (req_bus.word_index),
      .req_element_index (req_bus.element_index),
      .req_value         (req_bus.value),
      .cmd               (cmd),
      .scan_word         (scan_word),
      .stat              (stat),
      .rsp_best_index    (rsp_bus.best_index),
      .rsp_best_distance (rsp_bus.best_distance)
   );

endmodule

`default_nettype wire

/* bench/tb.sv */
// Self-checking testbench for the nearest codeword search block.
`timescale 1ns / 1ps

module tb;
   import ncs_pkg::*;

   localparam int MAX_WORDS = MAX_WORDS_DEF;
   localparam int MAX_DIM   = MAX_DIM_DEF;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   localparam longint unsigned SUM_MAX  = (64'd1 << SUM_W) - 64'd1;
   localparam longint unsigned DIST_MAX = 64'hFFFF_FFFF;

   localparam int  SETTLE_CYCLES = MAX_WORDS + 150;
   localparam int  HOLD_CYCLES   = 3000;
   localparam int  RANDOM_ITEMS  = 1350;
   localparam real LIMIT_NS      = 30_000_000.0;

   typedef struct packed {
      logic               mode;
      logic [IDX_W-1:0]   word_index;
      logic [IDX_W-1:0]   element_index;
      logic [VALUE_W-1:0] value;
   } ncs_beat_type;

   typedef struct packed {
      logic [IDX_W-1:0]  best_index;
      logic [DIST_W-1:0] best_distance;
   } nearest_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 csr_write_en;
   ncs_csr_type          csr_index;
   logic [CFG_W-1:0]     csr_data;

   ncs_req_if req_bus ();
   ncs_rsp_if rsp_bus ();

   nearest_codeword_search_top dut (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .rsp_bus      (rsp_bus),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state: codebook, per-word running sums, register copies
   logic [VALUE_W-1:0] book_model [0:MAX_WORDS*MAX_DIM-1];
   longint unsigned    sum_model  [0:MAX_WORDS-1];
   logic [CFG_W-1:0]   dim_cfg   = CFG_W'(1);
   logic [CFG_W-1:0]   words_cfg = CFG_W'(1);

   // Stimulus-side image of the codebook, kept in queue order
   logic [VALUE_W-1:0] book_image   [0:MAX_WORDS*MAX_DIM-1];
   bit                 book_written [0:MAX_WORDS*MAX_DIM-1];

   ncs_beat_type beats_to_send [$];
   nearest_type  expected_nearest [$];

   int send_idle_pct = 36;
   int recv_idle_pct = 65;
   int hold_left     = 0;
   logic hold_req;
   int error_count   = 0;
   int items_sent    = 0;

   initial begin
      foreach (sum_model[i]) sum_model[i] = '0;
   end

   function automatic logic [2*IDX_W-1:0] book_addr(int unsigned w, int unsigned e);
      return {IDX_W'(w), IDX_W'(e)};
   endfunction

   function automatic int unsigned clamp_cfg(logic [CFG_W-1:0] r, int unsigned top);
      if (r == '0) return 1;
      if (32'(r) > top) return top;
      return 32'(r);
   endfunction

   // Applies one accepted request beat; queues the result it causes, if any.
   function automatic void search_step(ncs_beat_type b);
      int unsigned d, n, w, best_w;
      int c, v, mag;
      longint unsigned sq, acc, best_sum, mean;
      nearest_type r;
      if (b.mode == MODE_WRITE) begin
         book_model[{b.word_index, b.element_index}] = b.value;
         return;
      end
      d = clamp_cfg(dim_cfg, MAX_DIM);
      n = clamp_cfg(words_cfg, MAX_WORDS);
      if (32'(b.element_index) >= d) return;
      v = int'($signed(b.value));
      for (w = 0; w < n; w++) begin
         c = int'($signed(book_model[book_addr(w, 32'(b.element_index))]));
         mag = (c > v) ? c - v : v - c;
         sq = longint'(mag) * longint'(mag);
         acc = (b.element_index == '0) ? sq : sum_model[IDX_W'(w)] + sq;
         if (acc > SUM_MAX) acc = SUM_MAX;
         sum_model[IDX_W'(w)] = acc;
      end
      if (32'(b.element_index) != d - 1) return;
      best_w = 0;
      best_sum = sum_model[0];
      for (w = 1; w < n; w++) begin
         if (sum_model[IDX_W'(w)] <= best_sum) begin
            best_sum = sum_model[IDX_W'(w)];
            best_w = w;
         end
      end
      mean = best_sum / 64'(d);
      if (mean > DIST_MAX) mean = DIST_MAX;
      r.best_index = IDX_W'(best_w);
      r.best_distance = DIST_W'(mean);
      expected_nearest.insert(expected_nearest.size(), r);
   endfunction

   // Request driver: a beat stays up until taken
   always @(posedge clock) begin : drive_req
      ncs_beat_type got, nxt;
      logic offer;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            got = {req_bus.mode, req_bus.word_index, req_bus.element_index, req_bus.value};
            search_step(got);
         end
         if (!req_bus.valid || req_bus.ready) begin
            offer = (beats_to_send.size() != 0) && ($urandom_range(99) >= send_idle_pct);
            if (offer) begin
               nxt = beats_to_send.pop_front();
               req_bus.mode          <= nxt.mode;
               req_bus.word_index    <= nxt.word_index;
               req_bus.element_index <= nxt.element_index;
               req_bus.value         <= nxt.value;
            end
            req_bus.valid <= offer;
         end
      end
   end

   always @(posedge clock) begin : hold_count
      if (reset) begin
         hold_left <= 0;
      end else if (hold_req) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Result monitor and receiver back-pressure
   always @(posedge clock) begin : watch_rsp
      nearest_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_nearest.size() == 0) begin
               $error("unexpected result beat: best_index %0d best_distance %0d",
                      rsp_bus.best_index, rsp_bus.best_distance);
               error_count++;
            end else begin
               want = expected_nearest.pop_front();
               if (rsp_bus.best_index !== want.best_index) begin
                  $error("best_index: expected %0d, actual %0d",
                         want.best_index, rsp_bus.best_index);
                  error_count++;
               end
               if (rsp_bus.best_distance !== want.best_distance) begin
                  $error("best_distance: expected %0d, actual %0d",
                         want.best_distance, rsp_bus.best_distance);
                  error_count++;
               end
            end
         end
         rsp_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   // Query element equal to or close to a stored codeword element, or a random value
   function automatic logic [VALUE_W-1:0] near_value(int unsigned w, int unsigned e);
      logic [VALUE_W-1:0] base;
      base = book_image[book_addr(w, e)];
      case ($urandom_range(3))
         0: return base;
         1: return base + VALUE_W'($urandom_range(32)) - VALUE_W'(16);
         default: return pick_value();
      endcase
   endfunction

   function automatic void enqueue_beat(ncs_beat_type b);
      beats_to_send.insert(beats_to_send.size(), b);
      items_sent++;
   endfunction

   function automatic void push_write(int unsigned w, int unsigned e, logic [VALUE_W-1:0] v);
      ncs_beat_type b;
      b.mode = MODE_WRITE;
      b.word_index = IDX_W'(w);
      b.element_index = IDX_W'(e);
      b.value = v;
      enqueue_beat(b);
      book_image[book_addr(w, e)] = v;
      book_written[book_addr(w, e)] = 1'b1;
   endfunction

   function automatic void push_query(int unsigned e, logic [VALUE_W-1:0] v);
      ncs_beat_type b;
      b.mode = MODE_QUERY;
      b.word_index = IDX_W'($urandom_range(255));
      b.element_index = IDX_W'(e);
      b.value = v;
      enqueue_beat(b);
   endfunction

   // Every codebook entry a query can touch must hold a written value
   function automatic void cover_region(int unsigned d, int unsigned n);
      for (int unsigned w = 0; w < n; w++)
         for (int unsigned e = 0; e < d; e++)
            if (!book_written[book_addr(w, e)]) push_write(w, e, pick_value());
   endfunction

   // Waits until the request queue is empty and every result is back
   task automatic drain();
      do @(negedge clock);
      while (beats_to_send.size() != 0 || req_bus.valid || expected_nearest.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(ncs_csr_type idx, logic [CFG_W-1:0] val);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == CSR_DIM) dim_cfg = val;
      else words_cfg = val;
   endtask

   task automatic set_config(int unsigned dim_val, int unsigned words_val);
      drain();
      write_csr(CSR_DIM, CFG_W'(dim_val));
      write_csr(CSR_NUM_WORDS, CFG_W'(words_val));
      @(negedge clock);
   endtask

   task automatic stall_receiver();
      @(posedge clock);
      hold_req <= 1'b1;
      @(posedge clock);
      hold_req <= 1'b0;
      @(negedge clock);
   endtask

   // One register setting worth of random traffic, mostly complete queries
   task automatic run_setting(int unsigned dim_val, int unsigned words_val,
                              int unsigned budget, bit hold_first);
      int unsigned d, n, made, e, w, r, s, len;
      set_config(dim_val, words_val);
      d = clamp_cfg(CFG_W'(dim_val), MAX_DIM);
      n = clamp_cfg(CFG_W'(words_val), MAX_WORDS);
      if (items_sent < 450) begin
         send_idle_pct = 36;
         recv_idle_pct = 65;
      end else if (items_sent < 900) begin
         send_idle_pct = 65;
         recv_idle_pct = 36;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      if (hold_first) stall_receiver();
      cover_region(d, n);
      made = 0;
      while (made < budget) begin
         r = $urandom_range(99);
         w = $urandom_range(n - 1);
         if (r < 70) begin
            for (e = 0; e < d; e++) push_query(e, near_value(w, e));
            made += d;
         end else if (r < 80) begin
            push_write($urandom_range(255), $urandom_range(255), pick_value());
            made++;
         end else if (r < 88 && d < MAX_DIM) begin
            // element past the vector length: dropped by the block
            push_query($urandom_range(255, d), pick_value());
         end else begin
            // partial or out-of-order run of elements
            s = ($urandom_range(1) == 0) ? 0 : $urandom_range(d - 1);
            len = $urandom_range(d - s, 1);
            for (e = s; e < s + len; e++) push_query(e, near_value(w, e));
            made += len;
         end
      end
   endtask

   initial begin
      #(LIMIT_NS);
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      req_bus.valid         = 1'b0;
      req_bus.mode          = MODE_WRITE;
      req_bus.word_index    = '0;
      req_bus.element_index = '0;
      req_bus.value         = '0;
      rsp_bus.ready         = 1'b0;
      csr_write_en          = 1'b0;
      csr_index             = CSR_DIM;
      csr_data              = '0;
      hold_req              = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset setting: one word, one element
      push_write(0, 0, 16'h8000);
      push_query(0, 16'h7FFF);
      push_query(0, 16'h8000);
      push_write(255, 255, 16'h7FFF);
      push_query(3, 16'h0000);

      // zero in both registers behaves as one
      set_config(0, 0);
      push_query(0, 16'h0001);

      // tie between words 1 and 2, then a restart-less element
      set_config(3, 3);
      for (int e = 0; e < 3; e++) begin
         push_write(0, e, 16'h0100);
         push_write(1, e, 16'h0000);
         push_write(2, e, 16'h0000);
      end
      for (int e = 0; e < 3; e++) push_query(e, 16'h0000);
      push_query(2, 16'h0100);
      push_query(7, 16'h1234);

      // mean distance clips at all ones
      set_config(2, 1);
      push_write(0, 0, 16'h8000);
      push_write(0, 1, 16'h8000);
      push_query(0, 16'h7FFF);
      repeat (3) push_query(1, 16'h7FFF);

      run_setting(2, 4, 150, 1'b1);
      run_setting(1, 256, 40, 1'b0);
      run_setting(1, 300, 20, 1'b0);

      // dim past the array size acts as 256: element 255 ends the vector
      set_config(511, 1);
      push_write(0, 255, 16'h7FFF);
      push_query(0, 16'h8000);
      push_query(255, 16'h8000);

      run_setting(0, 7, 80, 1'b0);
      run_setting(5, 0, 80, 1'b0);

      while (items_sent < RANDOM_ITEMS)
         run_setting($urandom_range(12, 1), $urandom_range(24, 1), 100, 1'b0);

      drain();
      if (error_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule

/* files.f */
rtl/ncs_pkg.sv
rtl/ncs_req_if.sv
rtl/ncs_rsp_if.sv
rtl/ncs_datapath.sv
rtl/ncs_ctrl.sv
rtl/nearest_codeword_search_top.sv
bench/tb.sv
